/* hdl/cba_pkg.sv */
package cba_pkg;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [4:0] FREED_MAX = 5'd31;

    typedef struct packed {
        logic clear;
        logic step;
        logic free_here;
    } scan_ctl_t;

endpackage

/* hdl/cba_ram.sv */
module cba_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/cba_hole_scan.sv */
module cba_hole_scan #(
    parameter int BLOCKS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cba_pkg::scan_ctl_t        ctl,
    input  logic [$clog2(BLOCKS)-1:0] idx,
    input  logic [1:0]                policy,
    input  logic [4:0]                size,
    output logic                      found,
    output logic [$clog2(BLOCKS)-1:0] best_start
);

    localparam int AW = $clog2(BLOCKS);
    localparam int CW = $clog2(BLOCKS + 1);
    localparam int LW = CW + 5;

    logic [AW-1:0] run_start_reg;
    logic [CW-1:0] run_len_reg;
    logic          found_reg;
    logic [AW-1:0] best_start_reg;
    logic [CW-1:0] best_len_reg;
    logic          fits;
    logic          take;

    assign fits = LW'(run_len_reg) >= LW'(size);

    always_comb
    begin
        take = 1'b0;
        if (fits)
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else if (policy == cba_pkg::POL_BEST)
            begin
                take = run_len_reg < best_len_reg;
            end
            else if (policy == cba_pkg::POL_WORST)
            begin
                take = run_len_reg > best_len_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg <= '0;
            found_reg   <= 1'b0;
        end
        else if (ctl.clear)
        begin
            run_len_reg <= '0;
            found_reg   <= 1'b0;
        end
        else if (ctl.step)
        begin
            if (ctl.free_here)
            begin
                run_len_reg <= run_len_reg + CW'(1);
            end
            else
            begin
                run_len_reg <= '0;
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            best_start_reg <= '0;
            best_len_reg   <= '0;
        end
        else if (ctl.step)
        begin
            if (ctl.free_here)
            begin
                if (run_len_reg == '0)
                begin
                    run_start_reg <= idx;
                end
            end
            else if (take)
            begin
                best_start_reg <= run_start_reg;
                best_len_reg   <= run_len_reg;
            end
        end
    end

    assign found      = found_reg;
    assign best_start = best_start_reg;

endmodule

/* hdl/contiguous_block_allocator.sv */
// one request at a time; the next input transfer is taken from the cycle after the
// result register is loaded
// reset: asynchronous active low; a clearing pass then frees every block, and no
// input transfer is taken until it ends
module contiguous_block_allocator #(
    parameter int BLOCKS     = 16,
    parameter int OWNER_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       operation,
    input  logic [1:0] policy,
    input  logic [7:0] owner_id,
    input  logic [4:0] size_requested,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [3:0] start_address,
    output logic [3:0] end_address,
    output logic [4:0] freed_count
);

    localparam int AW = $clog2(BLOCKS);
    localparam int CW = $clog2(BLOCKS + 1);
    localparam int DW = OWNER_BITS + 1;
    localparam int EW = AW + 5;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SCAN_END = 3'd3;
    localparam logic [2:0] S_MARK     = 3'd4;
    localparam logic [2:0] S_REL      = 3'd5;
    localparam logic [2:0] S_RESP     = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_idx_reg, pend_idx_next;
    logic [4:0]            mark_cnt_reg, mark_cnt_next;
    logic [4:0]            freed_reg, freed_next;

    logic [1:0]            req_policy_reg;
    logic [OWNER_BITS-1:0] req_owner_reg;
    logic [4:0]            req_size_reg;

    logic [1:0]            res_status_reg, res_status_next;
    logic [3:0]            res_start_reg, res_start_next;
    logic [3:0]            res_end_reg, res_end_next;

    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            out_status_reg;
    logic [3:0]            out_start_reg;
    logic [3:0]            out_end_reg;
    logic [4:0]            out_freed_reg;

    logic [OWNER_BITS+7:0] owner_ext;
    logic [OWNER_BITS-1:0] owner_in;
    logic                  in_xfer;
    logic                  req_invalid;
    logic                  resp_load;
    logic                  cnt_done;
    logic                  hit;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DW-1:0]         ram_wdata;
    logic [DW-1:0]         ram_rdata;

    cba_pkg::scan_ctl_t    scan_ctl;
    logic                  scan_found;
    logic [AW-1:0]         scan_start;
    logic [EW-1:0]         end_sum;
    logic [EW-1:0]         start_ext;
    logic [EW-1:0]         mark_sum;

    assign owner_ext   = {{OWNER_BITS{1'b0}}, owner_id};
    assign owner_in    = owner_ext[OWNER_BITS-1:0];
    assign in_stall    = state_reg != S_IDLE;
    assign in_xfer     = in_valid && !in_stall;
    assign req_invalid = (size_requested == 5'd0) || (32'(size_requested) > BLOCKS)
                         || (policy != cba_pkg::POL_FIRST && policy != cba_pkg::POL_BEST
                             && policy != cba_pkg::POL_WORST);
    assign cnt_done    = cnt_reg == CW'(BLOCKS);
    assign hit         = ram_rdata[OWNER_BITS]
                         && (ram_rdata[OWNER_BITS-1:0] == req_owner_reg);
    assign resp_load   = (state_reg == S_RESP) && (!out_valid_reg || !out_stall);
    assign start_ext   = EW'(scan_start);
    assign end_sum     = start_ext + EW'(req_size_reg) - EW'(1);
    assign mark_sum    = start_ext + EW'(mark_cnt_reg);

    cba_ram #(
        .WIDTH (DW),
        .DEPTH (BLOCKS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    cba_hole_scan #(
        .BLOCKS (BLOCKS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .idx        (pend_idx_reg),
        .policy     (req_policy_reg),
        .size       (req_size_reg),
        .found      (scan_found),
        .best_start (scan_start)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_next       = 1'b0;
        pend_idx_next   = cnt_reg[AW-1:0];
        mark_cnt_next   = mark_cnt_reg;
        freed_next      = freed_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_end_next    = res_end_reg;
        out_valid_next  = out_valid_reg && out_stall;
        scan_ctl        = '0;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg[AW-1:0];
        ram_wdata       = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(BLOCKS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cnt_next        = '0;
                    freed_next      = '0;
                    res_status_next = cba_pkg::ST_DONE;
                    res_start_next  = '0;
                    res_end_next    = '0;
                    if (operation == cba_pkg::OP_RELEASE)
                    begin
                        state_next = S_REL;
                    end
                    else if (req_invalid)
                    begin
                        res_status_next = cba_pkg::ST_INVALID;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        scan_ctl.clear = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (!cnt_done)
                begin
                    cnt_next  = cnt_reg + CW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    scan_ctl.step      = 1'b1;
                    scan_ctl.free_here = !ram_rdata[OWNER_BITS];
                end
                else if (cnt_done)
                begin
                    // closing step so a hole at the end of the map is counted
                    scan_ctl.step = 1'b1;
                    state_next    = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                if (scan_found)
                begin
                    res_start_next = start_ext[3:0];
                    res_end_next   = end_sum[3:0];
                    mark_cnt_next  = '0;
                    state_next     = S_MARK;
                end
                else
                begin
                    res_status_next = cba_pkg::ST_NOFIT;
                    state_next      = S_RESP;
                end
            end
            S_MARK:
            begin
                ram_we        = 1'b1;
                ram_waddr     = mark_sum[AW-1:0];
                ram_wdata     = {1'b1, req_owner_reg};
                mark_cnt_next = mark_cnt_reg + 5'd1;
                if (mark_cnt_reg == req_size_reg - 5'd1)
                begin
                    state_next = S_RESP;
                end
            end
            S_REL:
            begin
                if (!cnt_done)
                begin
                    cnt_next  = cnt_reg + CW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    if (hit)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = pend_idx_reg;
                        ram_wdata = {1'b0, req_owner_reg};
                        if (freed_reg != cba_pkg::FREED_MAX)
                        begin
                            freed_next = freed_reg + 5'd1;
                        end
                    end
                end
                else if (cnt_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (resp_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= pend_idx_next;
        mark_cnt_reg   <= mark_cnt_next;
        freed_reg      <= freed_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_end_reg    <= res_end_next;
        if (in_xfer)
        begin
            req_policy_reg <= policy;
            req_owner_reg  <= owner_in;
            req_size_reg   <= size_requested;
        end
        if (resp_load)
        begin
            out_status_reg <= res_status_reg;
            out_start_reg  <= res_start_reg;
            out_end_reg    <= res_end_reg;
            out_freed_reg  <= freed_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign start_address = out_start_reg;
    assign end_address   = out_end_reg;
    assign freed_count   = out_freed_reg;

endmodule
